>>> hdl/dts_pkg.sv
// shared types, constants and size table of the device table search core
`default_nettype none

package dts_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [7:0] END_CLASS   = 8'hFF;
  localparam logic [7:0] TYPE_NIBBLE = 8'h0F;
  localparam logic [7:0] ATTR_NIBBLE = 8'hF0;

  localparam int unsigned ROM_CLASSES = 12;
  localparam int unsigned ROM_TYPES   = 15;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_SEARCH   = 3'd1,
    OP_SET_ATTR = 3'd2,
    OP_CLR_ATTR = 3'd3,
    OP_SIZE     = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] entry_index;
    logic [7:0] dev_class;
    logic [7:0] dev_type;
    logic [7:0] node_id;
    logic       any_node;
    logic [7:0] occurrence;
    logic [7:0] attr_mask;
  } in_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] result_index;
    logic [5:0] dev_size;
    logic [7:0] entry_type;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0] dev_class;
    logic [7:0] dev_type;
    logic [7:0] node_id;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic     valid;
    out_rsp_t data;
  } rsp_t;

  localparam logic [5:0] SIZE_ROM [ROM_CLASSES][ROM_TYPES] = '{
    '{6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd1,  6'd1,  6'd2,  6'd2, 6'd2, 6'd2, 6'd2, 6'd2, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd4,  6'd1,  6'd2, 6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd2,  6'd2,  6'd2, 6'd4, 6'd4, 6'd4, 6'd4, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd2,  6'd2,  6'd2, 6'd4, 6'd4, 6'd4, 6'd4, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd1,  6'd2,  6'd0,  6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd32, 6'd16, 6'd10, 6'd10, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd2,  6'd4,  6'd2,  6'd4,  6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd4,  6'd1,  6'd2, 6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd4,  6'd1,  6'd2, 6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd2,  6'd1,  6'd2,  6'd1, 6'd2, 6'd4, 6'd1, 6'd2, 6'd4, 6'd0, 6'd0,
      6'd0, 6'd0},
    '{6'd0, 6'd1,  6'd1,  6'd2,  6'd1,  6'd2, 6'd2, 6'd1, 6'd4, 6'd4, 6'd1, 6'd1, 6'd0,
      6'd0, 6'd0}
  };

  function automatic logic [5:0] rom_size(logic [7:0] cls, logic [7:0] typ);
    logic [3:0] t;
    t = typ[3:0] & TYPE_NIBBLE[3:0];
    if ((32'(cls) >= ROM_CLASSES) || (32'(t) >= ROM_TYPES)) begin
      return 6'd0;
    end
    return SIZE_ROM[cls[3:0]][t];
  endfunction

  function automatic logic in_table(logic [7:0] idx);
    return 32'(idx) < TABLE_DEPTH;
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic [7:0] idx);
    return ADDR_W'(32'(idx));
  endfunction

endpackage

`default_nettype wire

>>> hdl/dts_ram.sv
// generic single write port ram with registered read
`default_nettype none

module dts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/dts_seq.sv
// sequencer: table clear, entry write, search walk, read-modify-write and size lookup
`default_nettype none

module dts_seq
  import dts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_req_t  in_data_i,
  output logic          in_ready_o,
  input  wire logic     slot_free_i,
  output rsp_t          rsp_o,
  output mem_req_t      mem_req_o,
  input  wire entry_t   mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH,
    ST_RMW,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  in_req_t           req_q, req_d;
  out_rsp_t          res_q, res_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [7:0]        cnt_q, cnt_d;

  logic accept;
  logic match;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  assign match = (mem_rdata_i.dev_class == req_q.dev_class) &&
                 ((mem_rdata_i.dev_type & TYPE_NIBBLE) == (req_q.dev_type & TYPE_NIBBLE)) &&
                 (req_q.any_node || (mem_rdata_i.node_id == req_q.node_id));

  always_comb begin
    logic [7:0] mask;
    logic [7:0] new_type;
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    mem_req_o = '{we: 1'b0, waddr: to_addr(req_q.entry_index), wdata: mem_rdata_i,
                  raddr: ptr_q};
    mask      = req_q.attr_mask & ATTR_NIBBLE;
    new_type  = mem_rdata_i.dev_type;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q;
        mem_req_o.wdata = '{dev_class: END_CLASS, dev_type: 8'd0, node_id: 8'd0};
        ptr_d           = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_req_o.raddr = to_addr(in_data_i.entry_index);
        if (accept) begin
          req_d   = in_data_i;
          res_d   = '0;
          cnt_d   = '0;
          state_d = ST_DONE;
          unique case (op_e'(in_data_i.op))
            OP_WRITE: begin
              if (in_table(in_data_i.entry_index)) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = to_addr(in_data_i.entry_index);
                mem_req_o.wdata = '{dev_class: in_data_i.dev_class,
                                    dev_type:  in_data_i.dev_type,
                                    node_id:   in_data_i.node_id};
                res_d.entry_type = in_data_i.dev_type;
              end
            end
            OP_SEARCH: begin
              mem_req_o.raddr = '0;
              ptr_d           = '0;
              state_d         = ST_SRCH;
            end
            OP_SET_ATTR, OP_CLR_ATTR, OP_SIZE: begin
              if (in_table(in_data_i.entry_index)) begin
                state_d = ST_RMW;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SRCH: begin
        mem_req_o.raddr = ptr_q + 1'b1;
        if (mem_rdata_i.dev_class == END_CLASS) begin
          res_d.status = 1'b1;
          state_d      = ST_DONE;
        end else if (match && (cnt_q == req_q.occurrence)) begin
          res_d.result_index = 8'(ptr_q);
          res_d.entry_type   = mem_rdata_i.dev_type;
          state_d            = ST_DONE;
        end else begin
          if (match) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (ptr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
            res_d.status = 1'b1;
            state_d      = ST_DONE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_RMW: begin
        state_d = ST_DONE;
        unique case (op_e'(req_q.op))
          OP_SET_ATTR: begin
            new_type = mem_rdata_i.dev_type | mask;
          end
          OP_CLR_ATTR: begin
            new_type = mem_rdata_i.dev_type & ~mask;
          end
          default: begin
            new_type = mem_rdata_i.dev_type;
          end
        endcase
        res_d.entry_type = new_type;
        if (op_e'(req_q.op) == OP_SIZE) begin
          res_d.dev_size = rom_size(mem_rdata_i.dev_class, mem_rdata_i.dev_type);
        end else begin
          mem_req_o.we             = 1'b1;
          mem_req_o.wdata.dev_type = new_type;
        end
      end
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o = '{valid: (state_q == ST_DONE), data: res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  a_no_write_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> !mem_req_o.we)
    else $error("memory write during search walk");

  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.status) |->
      (rsp_o.data.result_index == 8'd0 && rsp_o.data.entry_type == 8'd0 &&
       rsp_o.data.dev_size == 6'd0))
    else $error("failed search carries nonzero fields");

  a_size_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.dev_size != 6'd0) |-> (op_e'(req_q.op) == OP_SIZE))
    else $error("size reported for an op other than size query");

  a_write_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(in_data_i.op) == OP_WRITE) |=> (state_q == ST_DONE))
    else $error("write transaction did not complete in one cycle");

endmodule

`default_nettype wire

>>> hdl/device_table_search_core.sv
// top level of the device table search core: table memory, sequencer, output register
// write and unknown ops go from accept straight to the done state, set, clear and size
//   first pass through the read-modify-write state, search reads at most TABLE_DEPTH entries
// one transaction at a time, next accept in the cycle after the result is registered
// the search walk reads one table entry per cycle from the single read port
// reset: the table memory is swept to empty entry by entry, in_ready_o stays low until done
`default_nettype none

module device_table_search_core
  import dts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_rsp_t      out_data_o
);

  mem_req_t mem_req;
  entry_t   mem_rdata;
  rsp_t     rsp;
  logic     slot_free;
  logic     out_valid_q;
  out_rsp_t out_data_q;

  assign slot_free = !out_valid_q || out_ready_i;

  dts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  dts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .rsp_o       (rsp),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && rsp.valid) begin
      out_data_q <= rsp.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
